// File: hw/rtl/urb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urb_pkg
// Shared types and constants for the UART transmit/receive ring buffers.
// ----------------------------------------------------------------------------
package urb_pkg;

  // Default queue depths
  localparam int TX_DEPTH_DEF = 32;
  localparam int RX_DEPTH_DEF = 128;

  // Fill count width inside the block (holds a fill of up to 255)
  localparam int FILL_W    = 8;
  // Fill widths of the result beat
  localparam int TX_FILL_W = 6;
  localparam int RX_FILL_W = 8;

  // Characters
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Event codes
  typedef enum logic [1:0] {
    ACT_HOST_WRITE = 2'd0,
    ACT_HOST_READ  = 2'd1,
    ACT_LINE_RECV  = 2'd2,
    ACT_TX_READY   = 2'd3
  } act_t;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_TX_FULL  = 3'd1,
    STAT_RX_EMPTY = 3'd2,
    STAT_RX_DROP  = 3'd3,
    STAT_TX_EMPTY = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LF,
    S_DONE
  } state_t;

  // Queue command from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } q_cmd_t;

  // Queue status towards the sequencer
  typedef struct packed {
    logic              empty;
    logic              full;
    logic              room2;
    logic [FILL_W-1:0] fill;
  } q_stat_t;

endpackage

// File: hw/rtl/urb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urb_if
// Event and result channel interfaces (valid/ready handshake).
// ----------------------------------------------------------------------------
interface urb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] byte_in;

  modport source (output valid, output action, output byte_in, input ready);
  modport sink   (input valid, input action, input byte_in, output ready);
endinterface

interface urb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       byte_valid;
  logic [2:0] status;
  logic       tx_irq_enable;
  logic [5:0] tx_fill;
  logic [7:0] rx_fill;

  modport source (output valid, output byte_out, output byte_valid, output status,
                  output tx_irq_enable, output tx_fill, output rx_fill, input ready);
  modport sink   (input valid, input byte_out, input byte_valid, input status,
                  input tx_irq_enable, input tx_fill, input rx_fill, output ready);
endinterface

// File: hw/rtl/uart_tx_rx_ring_buffers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers
// Transmit and receive byte ring buffers between a host and a serial line.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  in_ch   | in  | action, byte_in
//  out_ch  | out | byte_out, byte_valid, status, tx_irq_enable, tx_fill, rx_fill
//
//  An event is accepted only in the idle state, so the next one waits until the
//  result of the last is loaded; a newline host write with room for two bytes
//  passes an extra state (carriage return and newline go through the single
//  transmit write port in turn); the result register loads in the done state.
//  Reset is synchronous: both queues empty, transmit interrupt enable set.
//  A stalled result beat holds the sequencer in its result state; one
//  further event can be accepted while a beat waits.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffers #(
  parameter int TX_DEPTH = urb_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  urb_in_if.sink    in_ch,
  urb_out_if.source out_ch
);

  urb_pkg::q_cmd_t  tx_cmd, rx_cmd;
  urb_pkg::q_stat_t tx_stat, rx_stat;
  logic [7:0]       tx_wdata, rx_wdata, tx_rdata, rx_rdata;

  // Transmit queue
  urb_queue #(.DEPTH(TX_DEPTH)) u_tx_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (tx_cmd),
    .wdata   (tx_wdata),
    .rdata_r (tx_rdata),
    .stat    (tx_stat)
  );

  // Receive queue
  urb_queue #(.DEPTH(RX_DEPTH)) u_rx_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (rx_cmd),
    .wdata   (rx_wdata),
    .rdata_r (rx_rdata),
    .stat    (rx_stat)
  );

  // Event sequencer
  urb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .tx_cmd   (tx_cmd),
    .rx_cmd   (rx_cmd),
    .tx_wdata (tx_wdata),
    .rx_wdata (rx_wdata),
    .tx_stat  (tx_stat),
    .rx_stat  (rx_stat),
    .tx_rdata (tx_rdata),
    .rx_rdata (rx_rdata)
  );

endmodule

// File: hw/rtl/urb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urb_queue
// Byte ring buffer: one-port-write / one-port-read memory with registered
// read data, and write/read pointers that count modulo twice the depth.
// ----------------------------------------------------------------------------
module urb_queue #(
  parameter int DEPTH = urb_pkg::TX_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  urb_pkg::q_cmd_t cmd,
  input  logic [7:0]      wdata,
  output logic [7:0]      rdata_r,
  output urb_pkg::q_stat_t stat
);

  localparam int PW = $clog2(2 * DEPTH);
  localparam int AW = $clog2(DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(2 * DEPTH - 1);
  localparam logic [PW:0]   TWO_D   = (PW + 1)'(2 * DEPTH);
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] wslot_full, rslot_full;
  logic [AW-1:0] wslot, rslot;
  logic [PW:0]   diff, fill;

  // Storage slot is the pointer folded into 0..DEPTH-1
  always_comb begin
    wslot_full = (wp_r >= DEPTH_P) ? wp_r - DEPTH_P : wp_r;
    rslot_full = (rp_r >= DEPTH_P) ? rp_r - DEPTH_P : rp_r;
    wslot      = wslot_full[AW-1:0];
    rslot      = rslot_full[AW-1:0];
  end

  // Pointer advance, wrapping at twice the depth
  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (cmd.push) begin
      wp_nxt = (wp_r == LAST_P) ? '0 : wp_r + 1'b1;
    end
    if (cmd.pop) begin
      rp_nxt = (rp_r == LAST_P) ? '0 : rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  // Memory: write and registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wslot] <= wdata;
    end
    if (cmd.pop) begin
      rdata_r <= mem[rslot];
    end
  end

  // Fill level and room flags
  always_comb begin
    diff = {1'b0, wp_r} - {1'b0, rp_r};
    fill = (wp_r >= rp_r) ? diff : diff + TWO_D;
    stat.fill  = urb_pkg::FILL_W'(fill);
    stat.empty = (fill == '0);
    stat.full  = (fill >= DEPTH_W);
    stat.room2 = (fill + (PW + 1)'(2) <= DEPTH_W);
  end

endmodule

// File: hw/rtl/urb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urb_ctrl
// Event sequencer: decodes one event, drives the queue commands, keeps the
// transmit interrupt enable and loads the result register.
// ----------------------------------------------------------------------------
module urb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  urb_in_if.sink           in_ch,
  urb_out_if.source        out_ch,
  output urb_pkg::q_cmd_t  tx_cmd,
  output urb_pkg::q_cmd_t  rx_cmd,
  output logic [7:0]       tx_wdata,
  output logic [7:0]       rx_wdata,
  input  urb_pkg::q_stat_t tx_stat,
  input  urb_pkg::q_stat_t rx_stat,
  input  logic [7:0]       tx_rdata,
  input  logic [7:0]       rx_rdata
);

  urb_pkg::state_t  state_r, state_nxt;
  urb_pkg::act_t    act;
  urb_pkg::status_t pend_status_r, pend_status_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             pend_tx_r, pend_tx_nxt;
  logic             irq_r, irq_nxt;
  logic             accept, is_lf, load;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_bvalid_r, out_bvalid_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  logic             out_irq_r, out_irq_nxt;
  logic [5:0]       out_txf_r, out_txf_nxt;
  logic [7:0]       out_rxf_r, out_rxf_nxt;

  assign in_ch.ready = (state_r == urb_pkg::S_IDLE);
  assign act    = urb_pkg::act_t'(in_ch.action);
  assign is_lf  = (in_ch.byte_in == urb_pkg::CH_LF);
  assign accept = in_ch.valid && in_ch.ready;
  assign load   = (state_r == urb_pkg::S_DONE) && (!out_valid_r || out_ch.ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      urb_pkg::S_IDLE: begin
        if (accept) begin
          if (act == urb_pkg::ACT_HOST_WRITE && is_lf && tx_stat.room2) begin
            state_nxt = urb_pkg::S_LF;
          end else begin
            state_nxt = urb_pkg::S_DONE;
          end
        end
      end
      urb_pkg::S_LF:   state_nxt = urb_pkg::S_DONE;
      urb_pkg::S_DONE: if (load) state_nxt = urb_pkg::S_IDLE;
      default:         state_nxt = urb_pkg::S_IDLE;
    endcase
  end

  // Outputs: queue commands, write data and pending result
  always_comb begin
    tx_cmd          = '0;
    rx_cmd          = '0;
    tx_wdata        = (state_r == urb_pkg::S_LF) ? urb_pkg::CH_LF :
                      (is_lf ? urb_pkg::CH_CR : in_ch.byte_in);
    rx_wdata        = in_ch.byte_in;
    pend_status_nxt = pend_status_r;
    pend_valid_nxt  = pend_valid_r;
    pend_tx_nxt     = pend_tx_r;
    irq_nxt         = irq_r;
    case (state_r)
      urb_pkg::S_IDLE: begin
        if (accept) begin
          pend_status_nxt = urb_pkg::STAT_OK;
          pend_valid_nxt  = 1'b0;
          pend_tx_nxt     = 1'b0;
          case (act)
            urb_pkg::ACT_HOST_WRITE: begin
              if (is_lf ? !tx_stat.room2 : tx_stat.full) begin
                pend_status_nxt = urb_pkg::STAT_TX_FULL;
              end else begin
                tx_cmd.push = 1'b1;
                irq_nxt     = 1'b1;
              end
            end
            urb_pkg::ACT_HOST_READ: begin
              if (rx_stat.empty) begin
                pend_status_nxt = urb_pkg::STAT_RX_EMPTY;
              end else begin
                rx_cmd.pop     = 1'b1;
                pend_valid_nxt = 1'b1;
              end
            end
            urb_pkg::ACT_LINE_RECV: begin
              if (rx_stat.full) begin
                pend_status_nxt = urb_pkg::STAT_RX_DROP;
              end else begin
                rx_cmd.push = 1'b1;
              end
            end
            default: begin
              if (tx_stat.empty) begin
                pend_status_nxt = urb_pkg::STAT_TX_EMPTY;
                irq_nxt         = 1'b0;
              end else begin
                tx_cmd.pop     = 1'b1;
                pend_valid_nxt = 1'b1;
                pend_tx_nxt    = 1'b1;
              end
            end
          endcase
        end
      end
      // second write of a newline pair
      urb_pkg::S_LF: tx_cmd.push = 1'b1;
      default: ;
    endcase
  end

  // Result register next values
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_byte_nxt   = out_byte_r;
    out_bvalid_nxt = out_bvalid_r;
    out_status_nxt = out_status_r;
    out_irq_nxt    = out_irq_r;
    out_txf_nxt    = out_txf_r;
    out_rxf_nxt    = out_rxf_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = pend_valid_r ? (pend_tx_r ? tx_rdata : rx_rdata) : 8'h00;
      out_bvalid_nxt = pend_valid_r;
      out_status_nxt = pend_status_r;
      out_irq_nxt    = irq_r;
      out_txf_nxt    = tx_stat.fill[urb_pkg::TX_FILL_W-1:0];
      out_rxf_nxt    = rx_stat.fill[urb_pkg::RX_FILL_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= urb_pkg::S_IDLE;
      irq_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      irq_r       <= irq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_valid_r  <= pend_valid_nxt;
    pend_tx_r     <= pend_tx_nxt;
    out_byte_r    <= out_byte_nxt;
    out_bvalid_r  <= out_bvalid_nxt;
    out_status_r  <= out_status_nxt;
    out_irq_r     <= out_irq_nxt;
    out_txf_r     <= out_txf_nxt;
    out_rxf_r     <= out_rxf_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.byte_out      = out_byte_r;
  assign out_ch.byte_valid    = out_bvalid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.tx_irq_enable = out_irq_r;
  assign out_ch.tx_fill       = out_txf_r;
  assign out_ch.rx_fill       = out_rxf_r;

endmodule

// File: hw/rtl/urb_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urb_chk
// Port-level checks on the result channel of the ring buffer block.
// ----------------------------------------------------------------------------
module urb_chk #(
  parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_byte_valid,
  input logic [2:0] out_status,
  input logic       out_tx_irq_enable,
  input logic [5:0] out_tx_fill,
  input logic [7:0] out_rx_fill
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A delivered byte always comes with an ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_status == urb_pkg::STAT_OK)
    else $error("byte delivered with error status");

  // Transmit empty clears the interrupt enable and shows an empty queue
  a_tx_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == urb_pkg::STAT_TX_EMPTY
      |-> !out_tx_irq_enable && out_tx_fill == '0 && !out_byte_valid)
    else $error("transmit empty beat inconsistent");

  // Receive empty shows no byte and an empty receive queue
  a_rx_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == urb_pkg::STAT_RX_EMPTY
      |-> !out_byte_valid && out_rx_fill == '0)
    else $error("receive empty beat inconsistent");

  // Receive fill never passes the queue depth
  a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rx_fill <= 8'(RX_DEPTH))
    else $error("receive fill beyond depth");

endmodule

bind uart_tx_rx_ring_buffers urb_chk #(.RX_DEPTH(RX_DEPTH)) u_urb_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_byte_valid    (out_ch.byte_valid),
  .out_status        (out_ch.status),
  .out_tx_irq_enable (out_ch.tx_irq_enable),
  .out_tx_fill       (out_ch.tx_fill),
  .out_rx_fill       (out_ch.rx_fill)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UART transmit/receive ring buffers. Events go
// in over the event channel; an internal copy of both queues and the
// interrupt enable predicts every result beat, which is compared field by
// field in order. Directed events cover the corner cases, then bursts of
// weighted random events fill and drain both queues under varying idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int TXD       = urb_pkg::TX_DEPTH_DEF;
  localparam int RXD       = urb_pkg::RX_DEPTH_DEF;
  localparam int TX_AW     = $clog2(TXD);
  localparam int RX_AW     = $clog2(RXD);
  localparam int N_RANDOM  = 1630;
  localparam int CYC_LIMIT = 400000;

  // One result beat as the block presents it
  typedef struct packed {
    logic [7:0]                    byte_out;
    logic                          byte_valid;
    logic [2:0]                    status;
    logic                          irq_en;
    logic [urb_pkg::TX_FILL_W-1:0] tx_fill;
    logic [urb_pkg::RX_FILL_W-1:0] rx_fill;
  } reply_t;

  // --------------------------------------------------------------------------
  // Queue model and in-order reply checker
  // --------------------------------------------------------------------------
  class ring_event_checker;
    logic [7:0]     tx_mem [TXD];
    logic [7:0]     rx_mem [RXD];
    logic [TX_AW:0] tx_wr, tx_rd;
    logic [RX_AW:0] rx_wr, rx_rd;
    logic           irq_en;
    reply_t         due_replies [$];

    function new();
      tx_wr  = '0;
      tx_rd  = '0;
      rx_wr  = '0;
      rx_rd  = '0;
      irq_en = 1'b1;
    endfunction

    function void push_tx(logic [7:0] b);
      tx_mem[tx_wr[TX_AW-1:0]] = b;
      tx_wr++;
    endfunction

    // Apply one accepted event and queue the reply it should produce
    function void note_event(urb_pkg::act_t a, logic [7:0] b);
      logic [TX_AW:0] tx_lvl;
      logic [RX_AW:0] rx_lvl;
      int             need;
      reply_t         r;
      tx_lvl = tx_wr - tx_rd;
      rx_lvl = rx_wr - rx_rd;
      r = '0;
      r.status = urb_pkg::STAT_OK;
      case (a)
        urb_pkg::ACT_HOST_WRITE: begin
          // newline goes out as CR then LF, needs two free slots
          need = (b == urb_pkg::CH_LF) ? 2 : 1;
          if (TXD - int'(tx_lvl) < need) begin
            r.status = urb_pkg::STAT_TX_FULL;
          end else begin
            if (b == urb_pkg::CH_LF) push_tx(urb_pkg::CH_CR);
            push_tx(b);
            irq_en = 1'b1;
          end
        end
        urb_pkg::ACT_HOST_READ: begin
          if (rx_lvl == 0) begin
            r.status = urb_pkg::STAT_RX_EMPTY;
          end else begin
            r.byte_out   = rx_mem[rx_rd[RX_AW-1:0]];
            r.byte_valid = 1'b1;
            rx_rd++;
          end
        end
        urb_pkg::ACT_LINE_RECV: begin
          if (int'(rx_lvl) >= RXD) begin
            r.status = urb_pkg::STAT_RX_DROP;
          end else begin
            rx_mem[rx_wr[RX_AW-1:0]] = b;
            rx_wr++;
          end
        end
        default: begin
          // transmitter ready: pop regardless of the enable
          if (tx_lvl == 0) begin
            irq_en   = 1'b0;
            r.status = urb_pkg::STAT_TX_EMPTY;
          end else begin
            r.byte_out   = tx_mem[tx_rd[TX_AW-1:0]];
            r.byte_valid = 1'b1;
            tx_rd++;
          end
        end
      endcase
      r.irq_en  = irq_en;
      r.tx_fill = urb_pkg::TX_FILL_W'(tx_wr - tx_rd);
      r.rx_fill = urb_pkg::RX_FILL_W'(rx_wr - rx_rd);
      due_replies.push_back(r);
    endfunction

    // Empty string when the beat matches the oldest expectation
    function string check_reply(reply_t got);
      reply_t exp;
      string  msg;
      if (due_replies.size() == 0) return "result beat with nothing expected";
      exp = due_replies.pop_front();
      msg = "";
      if (got.byte_out !== exp.byte_out)
        msg = {msg, $sformatf(" byte_out %h/%h", got.byte_out, exp.byte_out)};
      if (got.byte_valid !== exp.byte_valid)
        msg = {msg, $sformatf(" byte_valid %b/%b", got.byte_valid, exp.byte_valid)};
      if (got.status !== exp.status)
        msg = {msg, $sformatf(" status %0d/%0d", got.status, exp.status)};
      if (got.irq_en !== exp.irq_en)
        msg = {msg, $sformatf(" tx_irq_enable %b/%b", got.irq_en, exp.irq_en)};
      if (got.tx_fill !== exp.tx_fill)
        msg = {msg, $sformatf(" tx_fill %0d/%0d", got.tx_fill, exp.tx_fill)};
      if (got.rx_fill !== exp.rx_fill)
        msg = {msg, $sformatf(" rx_fill %0d/%0d", got.rx_fill, exp.rx_fill)};
      if (msg != "") msg = {"field mismatch (got/exp):", msg};
      return msg;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   n_errors;
  int   cyc_cnt;
  int   src_idle_pct;
  int   snk_stall_pct;
  string beat_msg;
  ring_event_checker sb;

  urb_in_if  in_ch ();
  urb_out_if out_ch ();

  uart_tx_rx_ring_buffers u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYC_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Monitor: events first, then result beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_event(urb_pkg::act_t'(in_ch.action), in_ch.byte_in);
      if (out_ch.valid && out_ch.ready) begin
        beat_msg = sb.check_reply({out_ch.byte_out, out_ch.byte_valid, out_ch.status,
                                   out_ch.tx_irq_enable, out_ch.tx_fill, out_ch.rx_fill});
        if (beat_msg != "") report_mismatch(beat_msg);
      end
    end
  end

  // Drive one event beat; valid stays high into the next call unless it idles
  task automatic send_event(input urb_pkg::act_t a, input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= a;
    in_ch.byte_in <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Weighted event choice per burst flavour
  function automatic urb_pkg::act_t pick_action(input int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      1:       return (r < 80) ? urb_pkg::ACT_HOST_WRITE :
                      (r < 90) ? urb_pkg::ACT_TX_READY :
                      (r < 95) ? urb_pkg::ACT_HOST_READ : urb_pkg::ACT_LINE_RECV;
      2:       return (r < 70) ? urb_pkg::ACT_TX_READY :
                      (r < 80) ? urb_pkg::ACT_HOST_WRITE :
                      (r < 90) ? urb_pkg::ACT_HOST_READ : urb_pkg::ACT_LINE_RECV;
      3:       return (r < 80) ? urb_pkg::ACT_LINE_RECV :
                      (r < 88) ? urb_pkg::ACT_HOST_READ :
                      (r < 94) ? urb_pkg::ACT_HOST_WRITE : urb_pkg::ACT_TX_READY;
      4:       return (r < 70) ? urb_pkg::ACT_HOST_READ :
                      (r < 80) ? urb_pkg::ACT_LINE_RECV :
                      (r < 90) ? urb_pkg::ACT_HOST_WRITE : urb_pkg::ACT_TX_READY;
      default: return urb_pkg::act_t'(r[1:0]);
    endcase
  endfunction

  // Idling phase changes every 200 events and repeats after four phases
  task automatic set_idling(input int n);
    case ((n / 200) % 4)
      0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1:       begin src_idle_pct = 74; snk_stall_pct = 0;  end
      2:       begin src_idle_pct = 0;  snk_stall_pct = 74; end
      default: begin src_idle_pct = 7;  snk_stall_pct = 7;  end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int            n_sent;
    int            mode;
    int            len;
    urb_pkg::act_t a;
    logic [7:0]    b;

    n_errors      = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    sb            = new();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= urb_pkg::ACT_HOST_READ;
    in_ch.byte_in <= 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty queues, disabled ready, byte extremes, newline expansion
    send_event(urb_pkg::ACT_HOST_READ, 8'hFF);
    send_event(urb_pkg::ACT_TX_READY, 8'hFF);
    send_event(urb_pkg::ACT_TX_READY, 8'h00);
    send_event(urb_pkg::ACT_HOST_WRITE, 8'h00);
    send_event(urb_pkg::ACT_HOST_WRITE, 8'hFF);
    send_event(urb_pkg::ACT_HOST_WRITE, urb_pkg::CH_LF);
    send_event(urb_pkg::ACT_HOST_WRITE, urb_pkg::CH_CR);
    repeat (5) send_event(urb_pkg::ACT_TX_READY, 8'hA5);
    send_event(urb_pkg::ACT_TX_READY, 8'h5A);
    send_event(urb_pkg::ACT_LINE_RECV, 8'h00);
    send_event(urb_pkg::ACT_LINE_RECV, 8'hFF);
    send_event(urb_pkg::ACT_LINE_RECV, urb_pkg::CH_LF);
    send_event(urb_pkg::ACT_LINE_RECV, 8'h55);
    repeat (4) send_event(urb_pkg::ACT_HOST_READ, 8'hAA);
    send_event(urb_pkg::ACT_HOST_READ, 8'h00);

    // Random bursts; fill flavours reach full queues, drops and refused newlines
    n_sent = 0;
    while (n_sent < N_RANDOM) begin
      mode = $urandom_range(0, 4);
      len  = $urandom_range(10, 180);
      for (int k = 0; k < len && n_sent < N_RANDOM; k++) begin
        set_idling(n_sent);
        a = pick_action(mode);
        b = 8'($urandom_range(0, 255));
        if (a == urb_pkg::ACT_HOST_WRITE && $urandom_range(0, 99) < 15) b = urb_pkg::CH_LF;
        send_event(a, b);
        n_sent++;
      end
    end
    in_ch.valid   <= 1'b0;
    snk_stall_pct = 0;

    // Drain, then allow for late or spurious beats
    while (sb.due_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0 && sb.due_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/urb_pkg.sv
hw/rtl/urb_if.sv
hw/rtl/urb_queue.sv
hw/rtl/urb_ctrl.sv
hw/rtl/uart_tx_rx_ring_buffers.sv
hw/rtl/urb_chk.sv
dv/tb.sv
